### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/llcp_pkg.sv
package llcp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_PLANE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd4;

    // Register reset values.
    localparam logic [30:0] NEAR_RST   = 31'd655;
    localparam logic [15:0] HSCALE_RST = 16'd1920;
    localparam logic [15:0] VSCALE_RST = 16'd1080;
    localparam logic [15:0] CX_RST     = 16'd960;
    localparam logic [15:0] CY_RST     = 16'd540;

    // Queue sizes.
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } t_seg;

    typedef struct packed {
        logic culled;
        logic a_clip;
        logic b_clip;
    } t_flags;

    typedef struct packed {
        t_flags flags;
        t_seg   seg;
    } t_item;

    typedef struct packed {
        t_flags             flags;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_result;

    // Quotient width of the projection divider: wide enough that any larger
    // quotient saturates the screen coordinate in both directions.
    function automatic int quot_width(input int frac);
        return ((32 > frac + 17) ? 32 : frac + 17) + 1;
    endfunction

endpackage

### sv/llcp_front.sv
module llcp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  llcp_pkg::t_seg     i_seg,
    input  logic [30:0]        i_nr,
    input  logic               i_pop,
    output logic               o_valid,
    output llcp_pkg::t_item    o_item
);

    localparam int AW = llcp_pkg::FQ_AW;

    llcp_pkg::t_item w_item;
    llcp_pkg::t_item r_mem [llcp_pkg::FQ_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;
    logic            w_a_behind;
    logic            w_b_behind;
    logic            w_wr_en;
    logic            w_rd_en;

    // Classify each endpoint against the near plane.
    always_comb begin
        w_a_behind = $signed({i_seg.az[31], i_seg.az}) <= $signed({2'b00, i_nr});
        w_b_behind = $signed({i_seg.bz[31], i_seg.bz}) <= $signed({2'b00, i_nr});
        w_item.seg = i_seg;
        w_item.flags.culled = w_a_behind && w_b_behind;
        w_item.flags.a_clip = w_a_behind && !w_b_behind;
        w_item.flags.b_clip = w_b_behind && !w_a_behind;
    end

    assign o_full  = (r_cnt == (AW+1)'(llcp_pkg::FQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && o_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= w_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/llcp_clip.sv
module llcp_clip #(
    parameter int FRAC_BITS = llcp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  llcp_pkg::t_item    i_item,
    input  logic [30:0]        i_nr,
    output logic               o_valid,
    output llcp_pkg::t_flags   o_flags,
    output logic signed [31:0] o_ax,
    output logic signed [31:0] o_ay,
    output logic signed [31:0] o_bx,
    output logic signed [31:0] o_by,
    output logic [30:0]        o_za,
    output logic [30:0]        o_zb
);

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = 32 + TW;

    typedef struct packed {
        llcp_pkg::t_flags   flags;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        za;
        logic [30:0]        zb;
        logic [31:0]        magx;
        logic [31:0]        magy;
        logic               negx;
        logic               negy;
    } t_ctx;

    logic signed [31:0] w_zin;
    logic signed [31:0] w_zout;
    logic signed [31:0] w_anx;
    logic signed [31:0] w_any;
    logic signed [31:0] w_otx;
    logic signed [31:0] w_oty;
    logic [32:0]        w_num33;
    logic [32:0]        w_den33;
    logic [32:0]        w_dx;
    logic [32:0]        w_dy;
    logic [32:0]        w_mx;
    logic [32:0]        w_my;
    t_ctx               w_ctx0;

    logic               r_v0;
    logic [30:0]        r_num0;
    logic [31:0]        r_den0;
    t_ctx               r_ctx0;

    logic               r_vd  [TW];
    logic [31:0]        r_rem [TW];
    logic [31:0]        r_den [TW];
    logic [TW-1:0]      r_q   [TW];
    t_ctx               r_ctx [TW];

    logic               r_vm;
    logic [PW-1:0]      r_prodx;
    logic [PW-1:0]      r_prody;
    t_ctx               r_ctxm;

    logic               r_vo;
    t_ctx               r_ctxo;

    logic signed [31:0] w_ancx;
    logic signed [31:0] w_ancy;
    logic [32:0]        w_px;
    logic [32:0]        w_py;
    logic [33:0]        w_movx;
    logic [33:0]        w_movy;
    t_ctx               w_ctxo;

    // Set up the clip: pick the endpoint in front as the anchor.
    always_comb begin
        if (i_item.flags.b_clip) begin
            w_zin  = i_item.seg.az;
            w_zout = i_item.seg.bz;
            w_anx  = i_item.seg.ax;
            w_any  = i_item.seg.ay;
            w_otx  = i_item.seg.bx;
            w_oty  = i_item.seg.by;
        end else begin
            w_zin  = i_item.seg.bz;
            w_zout = i_item.seg.az;
            w_anx  = i_item.seg.bx;
            w_any  = i_item.seg.by;
            w_otx  = i_item.seg.ax;
            w_oty  = i_item.seg.ay;
        end
        w_num33 = {w_zin[31], w_zin} - {2'b00, i_nr};
        w_den33 = {w_zin[31], w_zin} - {w_zout[31], w_zout};
        w_dx    = {w_otx[31], w_otx} - {w_anx[31], w_anx};
        w_dy    = {w_oty[31], w_oty} - {w_any[31], w_any};
        w_mx    = w_dx[32] ? (33'd0 - w_dx) : w_dx;
        w_my    = w_dy[32] ? (33'd0 - w_dy) : w_dy;
        w_ctx0.flags = i_item.flags;
        w_ctx0.ax    = i_item.seg.ax;
        w_ctx0.ay    = i_item.seg.ay;
        w_ctx0.bx    = i_item.seg.bx;
        w_ctx0.by    = i_item.seg.by;
        w_ctx0.za    = i_item.flags.a_clip ? i_nr : i_item.seg.az[30:0];
        w_ctx0.zb    = i_item.flags.b_clip ? i_nr : i_item.seg.bz[30:0];
        w_ctx0.magx  = w_mx[31:0];
        w_ctx0.magy  = w_my[31:0];
        w_ctx0.negx  = w_dx[32];
        w_ctx0.negy  = w_dy[32];
    end

    // Setup stage registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= w_num33[30:0];
            r_den0 <= w_den33[31:0];
            r_ctx0 <= w_ctx0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    // Clip factor divider: one quotient bit per stage, most significant first.
    for (genvar k = 0; k < TW; k++) begin : g_div
        logic [32:0]   w_trial;
        logic [32:0]   w_diff;
        logic [31:0]   w_dv;
        logic [TW-1:0] w_qin;
        t_ctx          w_cin;
        logic          w_vin;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_trial = {2'b00, r_num0};
            assign w_dv    = r_den0;
            assign w_qin   = '0;
            assign w_cin   = r_ctx0;
            assign w_vin   = r_v0;
        end else begin : g_next
            assign w_trial = {r_rem[k-1], 1'b0};
            assign w_dv    = r_den[k-1];
            assign w_qin   = r_q[k-1];
            assign w_cin   = r_ctx[k-1];
            assign w_vin   = r_vd[k-1];
        end

        assign w_ge   = w_trial >= {1'b0, w_dv};
        assign w_diff = w_trial - {1'b0, w_dv};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_den[k] <= w_dv;
                r_q[k]   <= {w_qin[TW-2:0], w_ge};
                r_ctx[k] <= w_cin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else if (i_en) begin
                r_vd[k] <= w_vin;
            end
        end
    end

    // Scale both coordinate differences by the clip factor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prodx <= PW'(r_ctx[TW-1].magx) * PW'(r_q[TW-1]);
            r_prody <= PW'(r_ctx[TW-1].magy) * PW'(r_q[TW-1]);
            r_ctxm  <= r_ctx[TW-1];
        end
    end

    // Move the clipped endpoint onto the near plane.
    always_comb begin
        w_ancx = r_ctxm.flags.b_clip ? r_ctxm.ax : r_ctxm.bx;
        w_ancy = r_ctxm.flags.b_clip ? r_ctxm.ay : r_ctxm.by;
        w_px   = r_prodx[PW-1:FRAC_BITS];
        w_py   = r_prody[PW-1:FRAC_BITS];
        w_movx = r_ctxm.negx ? ({{2{w_ancx[31]}}, w_ancx} - {1'b0, w_px})
                             : ({{2{w_ancx[31]}}, w_ancx} + {1'b0, w_px});
        w_movy = r_ctxm.negy ? ({{2{w_ancy[31]}}, w_ancy} - {1'b0, w_py})
                             : ({{2{w_ancy[31]}}, w_ancy} + {1'b0, w_py});
        w_ctxo = r_ctxm;
        if (r_ctxm.flags.b_clip) begin
            w_ctxo.bx = w_movx[31:0];
            w_ctxo.by = w_movy[31:0];
        end
        if (r_ctxm.flags.a_clip) begin
            w_ctxo.ax = w_movx[31:0];
            w_ctxo.ay = w_movy[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctxo <= w_ctxo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vm <= r_vd[TW-1];
            r_vo <= r_vm;
        end
    end

    assign o_valid = r_vo;
    assign o_flags = r_ctxo.flags;
    assign o_ax    = r_ctxo.ax;
    assign o_ay    = r_ctxo.ay;
    assign o_bx    = r_ctxo.bx;
    assign o_by    = r_ctxo.by;
    assign o_za    = r_ctxo.za;
    assign o_zb    = r_ctxo.zb;

endmodule

### sv/llcp_proj.sv
module llcp_proj #(
    parameter int FRAC_BITS = llcp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_c,
    input  logic [30:0]        i_zd,
    input  logic [15:0]        i_scale,
    input  logic [15:0]        i_center,
    output logic signed [31:0] o_val
);

    localparam int W    = llcp_pkg::quot_width(FRAC_BITS);
    localparam int SH   = W - FRAC_BITS;
    localparam int HI_W = 48 - SH;
    localparam int SW   = W + 3;

    logic [32:0]   w_c33;
    logic [32:0]   w_mag33;

    logic [47:0]   r_num;
    logic          r_neg1;
    logic [30:0]   r_zd1;

    logic [HI_W-1:0] w_hi;
    logic            w_ovf;
    logic [30:0]   r_rem0;
    logic [W-1:0]  r_low0;
    logic          r_ovf0;
    logic          r_neg0;
    logic [30:0]   r_zd0;

    logic [30:0]   r_rem [W];
    logic [W-1:0]  r_lo  [W];
    logic [W-1:0]  r_q   [W];
    logic          r_ovf [W];
    logic          r_ng  [W];
    logic [30:0]   r_z   [W];

    logic [W-1:0]  w_m;
    logic [SW-1:0] w_mag;
    logic [SW-1:0] w_sv;
    logic [SW-1:0] w_sum;
    logic          w_fits;
    logic signed [31:0] r_out;

    // Magnitude of the coordinate times the scale.
    always_comb begin
        w_c33   = {i_c[31], i_c};
        w_mag33 = i_c[31] ? (33'd0 - w_c33) : w_c33;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= 48'(w_mag33[31:0]) * 48'(i_scale);
            r_neg1 <= i_c[31];
            r_zd1  <= i_zd;
        end
    end

    // Overflow check on the top of the dividend, and the first remainder.
    assign w_hi  = r_num[47:SH];
    assign w_ovf = 48'(w_hi) >= 48'(r_zd1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= 31'(w_hi);
            r_low0 <= {r_num[SH-1:0], {FRAC_BITS{1'b0}}};
            r_ovf0 <= w_ovf;
            r_neg0 <= r_neg1;
            r_zd0  <= r_zd1;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar j = 0; j < W; j++) begin : g_div
        logic [30:0]  w_rin;
        logic [W-1:0] w_lin;
        logic [W-1:0] w_qin;
        logic         w_oin;
        logic         w_nin;
        logic [30:0]  w_zin;
        logic [31:0]  w_trial;
        logic [31:0]  w_diff;
        logic         w_ge;

        if (j == 0) begin : g_first
            assign w_rin = r_rem0;
            assign w_lin = r_low0;
            assign w_qin = '0;
            assign w_oin = r_ovf0;
            assign w_nin = r_neg0;
            assign w_zin = r_zd0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_lin = r_lo[j-1];
            assign w_qin = r_q[j-1];
            assign w_oin = r_ovf[j-1];
            assign w_nin = r_ng[j-1];
            assign w_zin = r_z[j-1];
        end

        assign w_trial = {w_rin, w_lin[W-1]};
        assign w_ge    = w_trial >= {1'b0, w_zin};
        assign w_diff  = w_trial - {1'b0, w_zin};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[30:0] : w_trial[30:0];
                r_lo[j]  <= {w_lin[W-2:0], 1'b0};
                r_q[j]   <= {w_qin[W-2:0], w_ge};
                r_ovf[j] <= w_oin;
                r_ng[j]  <= w_nin;
                r_z[j]   <= w_zin;
            end
        end
    end

    // Apply the sign, add the center and saturate to 32 bits.
    always_comb begin
        w_m    = r_ovf[W-1] ? {W{1'b1}} : r_q[W-1];
        w_mag  = SW'(w_m);
        w_sv   = r_ng[W-1] ? (SW'(0) - w_mag) : w_mag;
        w_sum  = w_sv + SW'({i_center, {FRAC_BITS{1'b0}}});
        w_fits = (w_sum[SW-1:31] == '0) || (w_sum[SW-1:31] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_fits) begin
                r_out <= w_sum[31:0];
            end else if (w_sum[SW-1]) begin
                r_out <= 32'sh8000_0000;
            end else begin
                r_out <= 32'sh7FFF_FFFF;
            end
        end
    end

    assign o_val = r_out;

endmodule

### sv/llcp_outq.sv
module llcp_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  llcp_pkg::t_result   i_data,
    output logic                o_ready,
    output logic                o_empty,
    input  logic                i_pop,
    output llcp_pkg::t_result   o_data
);

    localparam int AW = llcp_pkg::OQ_AW;

    llcp_pkg::t_result r_mem [llcp_pkg::OQ_DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              w_wr_en;
    logic              w_rd_en;

    assign o_ready = (r_cnt != (AW+1)'(llcp_pkg::OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && o_ready;
    assign w_rd_en = i_pop && !o_empty;

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/line_near_clip_perspective_project_top.sv
// Throughput: one segment per cycle while the output queue has room; the clip
// divider (FRAC_BITS + 1 stages) and the four projection dividers (W stages each,
// with W = max(32, FRAC_BITS + 17) + 1) are fully pipelined.
// Reset (synchronous, active low) empties both queues, clears the pipeline valids
// and loads the register defaults.
`include "assert_macros.svh"

module line_near_clip_perspective_project_top #(
    parameter int FRAC_BITS = llcp_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [31:0]                 i_first_x,
    input  logic signed [31:0]                 i_first_y,
    input  logic signed [31:0]                 i_first_z,
    input  logic signed [31:0]                 i_second_x,
    input  logic signed [31:0]                 i_second_y,
    input  logic signed [31:0]                 i_second_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [llcp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_culled,
    output logic                               o_first_clipped,
    output logic                               o_second_clipped,
    output logic signed [31:0]                 o_screen_ax,
    output logic signed [31:0]                 o_screen_ay,
    output logic signed [31:0]                 o_screen_bx,
    output logic signed [31:0]                 o_screen_by
);

    localparam int W  = llcp_pkg::quot_width(FRAC_BITS);
    localparam int PL = W + 3;

    logic [30:0]       r_near;
    logic [15:0]       r_hscale;
    logic [15:0]       r_vscale;
    logic [15:0]       r_cx;
    logic [15:0]       r_cy;
    logic [30:0]       w_nr;

    llcp_pkg::t_seg    w_seg;
    llcp_pkg::t_item   w_fr_item;
    logic              w_fr_valid;
    logic              w_adv;

    logic              w_cl_valid;
    llcp_pkg::t_flags  w_cl_flags;
    logic signed [31:0] w_cl_ax;
    logic signed [31:0] w_cl_ay;
    logic signed [31:0] w_cl_bx;
    logic signed [31:0] w_cl_by;
    logic [30:0]       w_cl_za;
    logic [30:0]       w_cl_zb;

    logic signed [31:0] w_pax;
    logic signed [31:0] w_pay;
    logic signed [31:0] w_pbx;
    logic signed [31:0] w_pby;

    logic              r_dv [PL];
    llcp_pkg::t_flags  r_df [PL];

    llcp_pkg::t_result w_res;
    llcp_pkg::t_result w_oq_data;
    logic              w_oq_push;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= llcp_pkg::NEAR_RST;
            r_hscale <= llcp_pkg::HSCALE_RST;
            r_vscale <= llcp_pkg::VSCALE_RST;
            r_cx     <= llcp_pkg::CX_RST;
            r_cy     <= llcp_pkg::CY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                llcp_pkg::REG_NEAR_PLANE:  r_near   <= i_cfg_data[30:0];
                llcp_pkg::REG_HORIZ_SCALE: r_hscale <= i_cfg_data[15:0];
                llcp_pkg::REG_VERT_SCALE:  r_vscale <= i_cfg_data[15:0];
                llcp_pkg::REG_CENTER_X:    r_cx     <= i_cfg_data[15:0];
                llcp_pkg::REG_CENTER_Y:    r_cy     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // A near plane of zero acts as the smallest positive depth.
    assign w_nr = (r_near == '0) ? 31'd1 : r_near;

    assign w_seg.ax = i_first_x;
    assign w_seg.ay = i_first_y;
    assign w_seg.az = i_first_z;
    assign w_seg.bx = i_second_x;
    assign w_seg.by = i_second_y;
    assign w_seg.bz = i_second_z;

    // Front: classification and the segment queue.
    llcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_seg   (w_seg),
        .i_nr    (w_nr),
        .i_pop   (w_adv),
        .o_valid (w_fr_valid),
        .o_item  (w_fr_item)
    );

    // Back: the whole pipeline moves while the output queue has room.
    llcp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_fr_valid),
        .i_item  (w_fr_item),
        .i_nr    (w_nr),
        .o_valid (w_cl_valid),
        .o_flags (w_cl_flags),
        .o_ax    (w_cl_ax),
        .o_ay    (w_cl_ay),
        .o_bx    (w_cl_bx),
        .o_by    (w_cl_by),
        .o_za    (w_cl_za),
        .o_zb    (w_cl_zb)
    );

    llcp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_ax (
        .i_clk (i_clk), .i_en (w_adv), .i_c (w_cl_ax), .i_zd (w_cl_za),
        .i_scale (r_hscale), .i_center (r_cx), .o_val (w_pax)
    );

    llcp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_ay (
        .i_clk (i_clk), .i_en (w_adv), .i_c (w_cl_ay), .i_zd (w_cl_za),
        .i_scale (r_vscale), .i_center (r_cy), .o_val (w_pay)
    );

    llcp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_bx (
        .i_clk (i_clk), .i_en (w_adv), .i_c (w_cl_bx), .i_zd (w_cl_zb),
        .i_scale (r_hscale), .i_center (r_cx), .o_val (w_pbx)
    );

    llcp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_by (
        .i_clk (i_clk), .i_en (w_adv), .i_c (w_cl_by), .i_zd (w_cl_zb),
        .i_scale (r_vscale), .i_center (r_cy), .o_val (w_pby)
    );

    // Valid and flag delay line matching the projection lanes.
    for (genvar s = 0; s < PL; s++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (w_adv) begin
                r_dv[s] <= (s == 0) ? w_cl_valid : r_dv[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_df[s] <= (s == 0) ? w_cl_flags : r_df[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // A culled segment reports zero coordinates.
    always_comb begin
        w_res.flags = r_df[PL-1];
        w_res.ax    = r_df[PL-1].culled ? 32'sd0 : w_pax;
        w_res.ay    = r_df[PL-1].culled ? 32'sd0 : w_pay;
        w_res.bx    = r_df[PL-1].culled ? 32'sd0 : w_pbx;
        w_res.by    = r_df[PL-1].culled ? 32'sd0 : w_pby;
    end

    assign w_oq_push = w_adv && r_dv[PL-1];

    llcp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_oq_push),
        .i_data  (w_res),
        .o_ready (w_adv),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_oq_data)
    );

    assign o_culled         = w_oq_data.flags.culled;
    assign o_first_clipped  = w_oq_data.flags.a_clip;
    assign o_second_clipped = w_oq_data.flags.b_clip;
    assign o_screen_ax      = w_oq_data.ax;
    assign o_screen_ay      = w_oq_data.ay;
    assign o_screen_bx      = w_oq_data.bx;
    assign o_screen_by      = w_oq_data.by;

    // A culled result carries no clip flags and zero first x and second y coordinates.
    `ASSERT_IMPLY(a_cull_zero, i_clk, i_rst_n, !empty && o_culled, !o_first_clipped && !o_second_clipped && o_screen_ax == 32'sd0 && o_screen_by == 32'sd0, "culled result has nonzero fields")
    // At most one endpoint is moved onto the near plane.
    `ASSERT_IMPLY(a_one_clip, i_clk, i_rst_n, !empty, !(o_first_clipped && o_second_clipped), "both endpoints marked clipped")
    // A finished result waiting on a full output queue is held, not dropped.
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_adv && r_dv[PL-1], r_dv[PL-1], "stalled result lost")

endmodule

### bench/llcp_checker.sv
`timescale 1ns / 1ps

// Watches the segment, configuration and result channels of the line clip and
// projection block, predicts every result and compares it with what comes out.
module llcp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  llcp_pkg::t_seg                 i_seg,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [llcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  llcp_pkg::t_result              i_result,
    output int                             o_errors,
    output int                             o_pending
);

    localparam int FRAC = llcp_pkg::FRAC_BITS_DEF;

    // Shadow copy of the configuration registers.
    logic [30:0] near_q;
    logic [15:0] hscale_q;
    logic [15:0] vscale_q;
    logic [15:0] cx_q;
    logic [15:0] cy_q;

    llcp_pkg::t_result expected_screen[$];

    // Clip factor in [0, 1] with FRAC fraction bits, truncated.
    function automatic longint unsigned clip_factor(longint zin, longint zout, longint nr);
        longint unsigned num;
        longint unsigned den;
        num = longint'(zin - nr);
        den = longint'(zin - zout);
        if (den == 0) return 0;
        return (num << FRAC) / den;
    endfunction

    // Moves a coordinate from the anchor toward the other end by factor t.
    function automatic longint slide(longint anchor, longint other, longint unsigned t);
        longint d;
        longint unsigned mag;
        longint p;
        d = other - anchor;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        p = longint'((mag * t) >> FRAC);
        return (d < 0) ? anchor - p : anchor + p;
    endfunction

    // Perspective divide plus screen offset, saturated to 32 bits.
    function automatic logic [31:0] to_screen(longint c, longint z, logic [15:0] scale,
                                              logic [15:0] center);
        longint unsigned mag;
        longint unsigned zd;
        longint unsigned num;
        longint unsigned q;
        longint unsigned r;
        longint unsigned m;
        longint val;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        zd = (z > 0) ? longint'(z) : 1;
        num = mag * scale;
        q = num / zd;
        r = num % zd;
        if (q > (64'd1 << 38)) q = 64'd1 << 38;
        m = (q << FRAC) + ((r << FRAC) / zd);
        val = (c < 0) ? -longint'(m) : longint'(m);
        val += longint'({48'd0, center}) << FRAC;
        if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
        if (val < -64'sh8000_0000) val = -64'sh8000_0000;
        return val[31:0];
    endfunction

    function automatic llcp_pkg::t_result predict_segment(llcp_pkg::t_seg s);
        llcp_pkg::t_result res;
        longint ax, ay, az, bx, by, bz, nr;
        logic a_behind, b_behind;
        longint unsigned t;
        ax = s.ax; ay = s.ay; az = s.az;
        bx = s.bx; by = s.by; bz = s.bz;
        nr = (near_q == 0) ? 1 : longint'({33'd0, near_q});
        a_behind = az <= nr;
        b_behind = bz <= nr;
        res = '0;
        if (a_behind && b_behind) begin
            res.flags.culled = 1'b1;
            return res;
        end
        if (b_behind) begin
            t = clip_factor(az, bz, nr);
            bx = slide(ax, bx, t);
            by = slide(ay, by, t);
            bz = nr;
        end
        if (a_behind) begin
            t = clip_factor(bz, az, nr);
            ax = slide(bx, ax, t);
            ay = slide(by, ay, t);
            az = nr;
        end
        res.flags.a_clip = a_behind;
        res.flags.b_clip = b_behind;
        res.ax = to_screen(ax, az, hscale_q, cx_q);
        res.ay = to_screen(ay, az, vscale_q, cy_q);
        res.bx = to_screen(bx, bz, hscale_q, cx_q);
        res.by = to_screen(by, bz, vscale_q, cy_q);
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    assign o_pending = expected_screen.size();

    // Track register writes, accepted segments and returned results.
    always @(posedge i_clk) begin
        llcp_pkg::t_result exp_r;
        if (!i_rst_n) begin
            near_q   <= llcp_pkg::NEAR_RST;
            hscale_q <= llcp_pkg::HSCALE_RST;
            vscale_q <= llcp_pkg::VSCALE_RST;
            cx_q     <= llcp_pkg::CX_RST;
            cy_q     <= llcp_pkg::CY_RST;
            o_errors = 0;
            expected_screen.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    llcp_pkg::REG_NEAR_PLANE:  near_q   <= i_cfg_data[30:0];
                    llcp_pkg::REG_HORIZ_SCALE: hscale_q <= i_cfg_data[15:0];
                    llcp_pkg::REG_VERT_SCALE:  vscale_q <= i_cfg_data[15:0];
                    llcp_pkg::REG_CENTER_X:    cx_q     <= i_cfg_data[15:0];
                    llcp_pkg::REG_CENTER_Y:    cy_q     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                expected_screen.push_back(predict_segment(i_seg));
            if (i_pop && !i_empty) begin
                if (expected_screen.size() == 0) begin
                    $error("result transaction with no segment outstanding");
                    o_errors++;
                end else begin
                    exp_r = expected_screen.pop_front();
                    compare_field("culled", 32'(exp_r.flags.culled),
                                  32'(i_result.flags.culled));
                    compare_field("first_clipped", 32'(exp_r.flags.a_clip),
                                  32'(i_result.flags.a_clip));
                    compare_field("second_clipped", 32'(exp_r.flags.b_clip),
                                  32'(i_result.flags.b_clip));
                    compare_field("screen_ax", exp_r.ax, i_result.ax);
                    compare_field("screen_ay", exp_r.ay, i_result.ay);
                    compare_field("screen_bx", exp_r.bx, i_result.bx);
                    compare_field("screen_by", exp_r.by, i_result.by);
                end
            end
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = 70;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    llcp_pkg::t_seg seg_q = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [llcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    llcp_pkg::t_result result_w;
    int          errors;
    int          pending;

    // Idle percentages of both sides and the long receiver hold-off request.
    int          send_idle = 23;
    int          recv_idle = 83;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic [30:0] near_now = llcp_pkg::NEAR_RST;
    int          cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    line_near_clip_perspective_project_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_first_x        (seg_q.ax),
        .i_first_y        (seg_q.ay),
        .i_first_z        (seg_q.az),
        .i_second_x       (seg_q.bx),
        .i_second_y       (seg_q.by),
        .i_second_z       (seg_q.bz),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .empty            (empty),
        .pop              (pop),
        .o_culled         (result_w.flags.culled),
        .o_first_clipped  (result_w.flags.a_clip),
        .o_second_clipped (result_w.flags.b_clip),
        .o_screen_ax      (result_w.ax),
        .o_screen_ay      (result_w.ay),
        .o_screen_bx      (result_w.bx),
        .o_screen_by      (result_w.by)
    );

    llcp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_seg       (seg_q),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (result_w),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Result side: random stalls plus one long hold-off on request.
    always @(posedge i_clk) begin
        int hold_cnt;
        if (hold_req && !hold_done && hold_cnt == 0) begin
            hold_cnt = 400;
            hold_done <= 1'b1;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[line_near_clip_perspective_project_top] ERROR");
            $finish;
        end
    end

    // One register write transaction; cfg_valid is then dropped before the task returns.
    task automatic write_reg(logic [llcp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == llcp_pkg::REG_NEAR_PLANE) near_now = value[30:0];
        @(posedge i_clk);
    endtask

    // Lets the pipeline drain completely before the registers change.
    task automatic drain_pipeline();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_view(logic [31:0] nr, logic [31:0] hs, logic [31:0] vs,
                            logic [31:0] cx, logic [31:0] cy);
        drain_pipeline();
        write_reg(llcp_pkg::REG_NEAR_PLANE, nr);
        write_reg(llcp_pkg::REG_HORIZ_SCALE, hs);
        write_reg(llcp_pkg::REG_VERT_SCALE, vs);
        write_reg(llcp_pkg::REG_CENTER_X, cx);
        write_reg(llcp_pkg::REG_CENTER_Y, cy);
    endtask

    // One segment transaction, with random idle cycles ahead of it.
    task automatic send_segment(llcp_pkg::t_seg s);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        seg_q <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Depths cluster around the near plane so that every clip case is common.
    function automatic logic [31:0] pick_depth();
        longint z;
        case ($urandom_range(4))
            0: z = $urandom;
            1: z = longint'(near_now) + $urandom_range(128) - 64;
            2: z = longint'(near_now) + $urandom_range(1 << 24);
            3: z = longint'(near_now) - $urandom_range(1 << 20);
            default: z = $urandom_range(1, 1 << 26);
        endcase
        return z[31:0];
    endfunction

    function automatic logic [31:0] pick_coord();
        logic [31:0] c;
        case ($urandom_range(2))
            0: c = $urandom;
            1: c = $urandom_range(1 << 22) - (1 << 21);
            default: c = $urandom_range(1 << 16) - (1 << 15);
        endcase
        return c;
    endfunction

    function automatic llcp_pkg::t_seg random_segment();
        llcp_pkg::t_seg s;
        s.ax = pick_coord();
        s.ay = pick_coord();
        s.az = pick_depth();
        s.bx = pick_coord();
        s.by = pick_coord();
        s.bz = pick_depth();
        return s;
    endfunction

    task automatic random_run(int count);
        repeat (count) send_segment(random_segment());
    endtask

    // Extremes of the fields and each clip case under the current view.
    task automatic directed_run();
        llcp_pkg::t_seg s;
        logic signed [31:0] nr;
        nr = (near_now == 0) ? 32'sd1 : signed'({1'b0, near_now});
        s = '{32'sd0, 32'sd0, nr, 32'sd0, 32'sd0, nr};
        send_segment(s);
        s = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF,
              -32'sh8000_0000, 32'sh7FFF_FFFF, nr + 1};
        send_segment(s);
        s = '{-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000,
              32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF};
        send_segment(s);
        s = '{32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_FFFF,
              -32'sh0002_0000, 32'sh0003_0000, nr};
        send_segment(s);
        s = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, nr + 1, -32'sh8000_0000, -32'sh8000_0000, nr + 1};
        send_segment(s);
        s = '{32'sh0, 32'sh0, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh1};
        send_segment(s);
        s = '{32'sh1234_5678, -32'sh0765_4321, nr + 2, 32'sh0, 32'sh0, nr + 2};
        send_segment(s);
        s = '{-32'sh1, 32'sh1, 32'sh0001_0000, 32'sh1, -32'sh1, 32'sh0002_0000};
        send_segment(s);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers, sender light idle and receiver heavy idle.
        directed_run();
        random_run(200);

        // Smallest depth, largest scales, zero centers; an unknown index too.
        set_view(32'd1, 32'd65535, 32'd65535, 32'd0, 32'd0);
        write_reg(3'd5, 32'hFFFF_FFFF);
        directed_run();
        random_run(200);

        // Swap the idle pattern; largest depth, unit scales, largest centers.
        send_idle = 83;
        recv_idle = 23;
        set_view(32'h7FFF_FFFF, 32'd1, 32'd1, 32'd65535, 32'd65535);
        write_reg(3'd7, 32'h0);
        directed_run();
        random_run(150);

        // Zero near plane and zero scales.
        set_view(32'd0, 32'd0, 32'd0, $urandom_range(65535), $urandom_range(65535));
        directed_run();
        random_run(150);

        // No idling: long receiver hold-off fills the block, then a full pause.
        send_idle = 0;
        recv_idle = 0;
        set_view($urandom_range(1 << 20, 1), $urandom, $urandom, $urandom, $urandom);
        hold_req <= 1'b1;
        random_run(200);
        drain_pipeline();
        random_run(200);

        // Every register bit driven high, then a random view.
        set_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_run(100);
        set_view($urandom_range(1 << 24, 1), $urandom, $urandom, $urandom, $urandom);
        random_run(100);

        drain_pipeline();
        if (errors == 0 && pending == 0)
            $display("[line_near_clip_perspective_project_top] OK");
        else
            $display("[line_near_clip_perspective_project_top] ERROR");
        $finish;
    end

endmodule
